// ===== design/rebe_pkg.sv =====
// shared types and constants for the rotary encoder button event decoder
`timescale 1ns / 1ps

package rebe_pkg;

  // event codes carried on the result channel
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DEC     = 3'd1,
    EV_INC     = 3'd2,
    EV_PUSH    = 3'd3,
    EV_RELEASE = 3'd4,
    EV_LONG    = 3'd5
  } event_e;

  localparam int unsigned ThreshWidth      = 16;
  localparam int unsigned TimerWidthDefault = 16;

  localparam logic [ThreshWidth-1:0] ThreshReset = 16'd1000;

  // pin vector order: bit 0 clock, bit 1 data, bit 2 switch
  localparam logic [2:0] PinsReset = 3'b001;

endpackage

// ===== design/rotary_encoder_button_events_core.sv =====
// rotary encoder and push button event decoder, top level
`timescale 1ns / 1ps

// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------------
// in        | input     | in_valid_i / in_stall_o   | clk_level_i dat_level_i sw_level_i tick_i
// out       | output    | out_valid_o / out_stall_i | event_res_o
// cfg       | input     | cfg_valid_i / cfg_ready_o | cfg_long_press_threshold_i
//
// one beat in, one beat out; the event is registered into the output register as the input beat is
// taken, and a new input beat can be taken every cycle while in_stall_o is low
// the decode is one pass of edge compare, timer increment and threshold compare
// in_stall_o rises only while the output register holds a beat that is itself stalled
// reset (rst_ni low, asynchronous) clears the pin history to clock high, the timer and
// the long-press wait flag, and loads the threshold with 1000
// cfg_ready_o is always high; the threshold is meant to be written while idle

module rotary_encoder_button_events_core #(
  parameter int unsigned TIMER_WIDTH = rebe_pkg::TimerWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               clk_level_i,
  input  logic                               dat_level_i,
  input  logic                               sw_level_i,
  input  logic                               tick_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         event_res_o,
  // threshold write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rebe_pkg::ThreshWidth-1:0]   cfg_long_press_threshold_i
);

  import rebe_pkg::*;

  // compare width covers both the timer and the 16-bit threshold
  localparam int unsigned CmpWidth = (TIMER_WIDTH > ThreshWidth) ? TIMER_WIDTH : ThreshWidth;

  // state
  logic [2:0]             pins_q, pins_d;
  logic                   long_wait_q, long_wait_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [ThreshWidth-1:0] thresh_q;

  // output register
  logic                   out_valid_q, out_valid_d;
  event_e                 event_q, event_d;

  logic                   in_acc;
  logic [2:0]             pins;
  logic                   same_cd;
  logic                   push;
  logic                   steady_pressed;
  logic                   long_hit;
  logic [TIMER_WIDTH-1:0] timer_tick;
  logic [TIMER_WIDTH-1:0] timer_mid;

  // handshakes
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;

  assign pins = {sw_level_i, dat_level_i, clk_level_i};

  // clock and data unchanged since the previous beat
  assign same_cd = (pins[1:0] == pins_q[1:0]);
  // falling switch with the encoder at rest
  assign push    = same_cd & pins_q[2] & ~sw_level_i;

  // millisecond timer, advanced by tick_i on taken beats, cleared on a push or a long press, saturating at all ones
  assign timer_tick = (tick_i && (timer_q != '1)) ? timer_q + TIMER_WIDTH'(1) : timer_q;
  assign timer_mid  = push ? '0 : timer_tick;

  // switch held down with clock equal to data
  assign steady_pressed = ~sw_level_i & (clk_level_i == dat_level_i);
  assign long_hit = steady_pressed & ~long_wait_q &
                    (CmpWidth'(timer_mid) >= CmpWidth'(thresh_q));

  // event decode, later checks override earlier ones
  always_comb begin
    event_d     = EV_NONE;
    long_wait_d = long_wait_q;
    timer_d     = timer_mid;
    pins_d      = pins;

    // rotation step on any clock pin change
    if (pins_q[0] != clk_level_i) begin
      event_d = (dat_level_i == clk_level_i) ? EV_INC : EV_DEC;
    end

    if (push) begin
      event_d = EV_PUSH;
    end else if (same_cd && !pins_q[2] && sw_level_i) begin
      // a release right after a long push is swallowed
      if (long_wait_q) begin
        long_wait_d = 1'b0;
      end else begin
        event_d = EV_RELEASE;
      end
    end

    if (long_hit) begin
      event_d     = EV_LONG;
      long_wait_d = 1'b1;
      timer_d     = '0;
    end
  end

  // output register fills on an input beat and drains when not stalled
  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q      <= PinsReset;
      long_wait_q <= 1'b0;
      timer_q     <= '0;
      thresh_q    <= ThreshReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        pins_q      <= pins_d;
        long_wait_q <= long_wait_d;
        timer_q     <= timer_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        thresh_q <= cfg_long_press_threshold_i;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      event_q <= event_d;
    end
  end

endmodule

// ===== design/rebe_checker.sv =====
// port-level assertions for the rotary encoder button event decoder
`timescale 1ns / 1ps

module rebe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] event_res_o
);

  import rebe_pkg::*;

  // a stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_res_o))
    else $error("result code changed while stalled");

  // every taken input beat yields a result beat in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("input beat produced no result");

  // input side stalls only behind a full, stalled output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // only defined event codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_res_o <= 3'(EV_LONG))
    else $error("undefined event code");

endmodule

bind rotary_encoder_button_events_core rebe_checker u_rebe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o)
);
